[design/char_lcd_nibble_interface_macros.svh]
// Assertion macros for the character LCD nibble interface.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_MACROS_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_MACROS_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define CLCD_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in this cycle, consequent in the next cycle.
`define CLCD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/clcd_pkg.sv]
// Types, constants and the control store of the character LCD nibble interface.
package clcd_pkg;

  localparam int FuncW   = 3;
  localparam int ByteW   = 8;
  localparam int ColumnW = 6;
  localparam int NibbleW = 4;
  localparam int HoldW   = 8;
  localparam int UpcW    = 6;
  localparam int CfgIdxW = 1;

  localparam logic [FuncW-1:0] FuncData   = 3'd0;
  localparam logic [FuncW-1:0] FuncCmd    = 3'd1;
  localparam logic [FuncW-1:0] FuncCursor = 3'd2;
  localparam logic [FuncW-1:0] FuncClear  = 3'd3;
  localparam logic [FuncW-1:0] FuncInit   = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgSecondRow = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPowerWait = 1'd1;

  localparam logic [ByteW-1:0] FirstRowBase     = 8'h80;
  localparam logic [ByteW-1:0] SecondRowReset   = 8'hC0;
  localparam logic [HoldW-1:0] PowerWaitReset   = 8'd50;

  localparam logic [UpcW-1:0] EntryByte  = 6'd0;
  localparam logic [UpcW-1:0] EntryClear = 6'd4;
  localparam logic [UpcW-1:0] EntryInit  = 6'd8;
  localparam logic [UpcW-1:0] LastAddr   = 6'd32;

  typedef enum logic [1:0] {
    NS_KEEP,
    NS_HI,
    NS_LO
  } nsel_e;

  typedef enum logic {
    OS_REQ,
    OS_CONST
  } osel_e;

  typedef enum logic {
    HS_CONST,
    HS_PWR
  } hsel_e;

  typedef struct packed {
    nsel_e             nsel;
    osel_e             osel;
    logic [ByteW-1:0]  cbyte;
    logic              en;
    hsel_e             hsel;
    logic [HoldW-1:0]  hold;
    logic              last;
  } uword_t;

  function automatic uword_t mk(input nsel_e ns, input osel_e os, input logic [ByteW-1:0] cb,
                                input logic en, input hsel_e hs,
                                input logic [HoldW-1:0] hold, input logic last);
    uword_t w;
    w.nsel  = ns;
    w.osel  = os;
    w.cbyte = cb;
    w.en    = en;
    w.hsel  = hs;
    w.hold  = hold;
    w.last  = last;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [UpcW-1:0] a);
    uword_t w;
    case (a)
      6'd0:  w = mk(NS_HI,   OS_REQ,   8'h00, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd1:  w = mk(NS_HI,   OS_REQ,   8'h00, 1'b0, HS_CONST, 8'd1, 1'b0);
      6'd2:  w = mk(NS_LO,   OS_REQ,   8'h00, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd3:  w = mk(NS_LO,   OS_REQ,   8'h00, 1'b0, HS_CONST, 8'd3, 1'b1);
      6'd4:  w = mk(NS_HI,   OS_CONST, 8'h01, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd5:  w = mk(NS_HI,   OS_CONST, 8'h01, 1'b0, HS_CONST, 8'd1, 1'b0);
      6'd6:  w = mk(NS_LO,   OS_CONST, 8'h01, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd7:  w = mk(NS_LO,   OS_CONST, 8'h01, 1'b0, HS_CONST, 8'd8, 1'b1);
      6'd8:  w = mk(NS_KEEP, OS_CONST, 8'h00, 1'b0, HS_PWR,   8'd0, 1'b0);
      6'd9:  w = mk(NS_HI,   OS_CONST, 8'h30, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd10: w = mk(NS_HI,   OS_CONST, 8'h30, 1'b0, HS_CONST, 8'd6, 1'b0);
      6'd11: w = mk(NS_HI,   OS_CONST, 8'h30, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd12: w = mk(NS_HI,   OS_CONST, 8'h30, 1'b0, HS_CONST, 8'd2, 1'b0);
      6'd13: w = mk(NS_HI,   OS_CONST, 8'h30, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd14: w = mk(NS_HI,   OS_CONST, 8'h30, 1'b0, HS_CONST, 8'd2, 1'b0);
      6'd15: w = mk(NS_HI,   OS_CONST, 8'h20, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd16: w = mk(NS_HI,   OS_CONST, 8'h20, 1'b0, HS_CONST, 8'd2, 1'b0);
      6'd17: w = mk(NS_HI,   OS_CONST, 8'h28, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd18: w = mk(NS_HI,   OS_CONST, 8'h28, 1'b0, HS_CONST, 8'd1, 1'b0);
      6'd19: w = mk(NS_LO,   OS_CONST, 8'h28, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd20: w = mk(NS_LO,   OS_CONST, 8'h28, 1'b0, HS_CONST, 8'd3, 1'b0);
      6'd21: w = mk(NS_HI,   OS_CONST, 8'h0C, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd22: w = mk(NS_HI,   OS_CONST, 8'h0C, 1'b0, HS_CONST, 8'd1, 1'b0);
      6'd23: w = mk(NS_LO,   OS_CONST, 8'h0C, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd24: w = mk(NS_LO,   OS_CONST, 8'h0C, 1'b0, HS_CONST, 8'd3, 1'b0);
      6'd25: w = mk(NS_HI,   OS_CONST, 8'h06, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd26: w = mk(NS_HI,   OS_CONST, 8'h06, 1'b0, HS_CONST, 8'd1, 1'b0);
      6'd27: w = mk(NS_LO,   OS_CONST, 8'h06, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd28: w = mk(NS_LO,   OS_CONST, 8'h06, 1'b0, HS_CONST, 8'd3, 1'b0);
      6'd29: w = mk(NS_HI,   OS_CONST, 8'h01, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd30: w = mk(NS_HI,   OS_CONST, 8'h01, 1'b0, HS_CONST, 8'd1, 1'b0);
      6'd31: w = mk(NS_LO,   OS_CONST, 8'h01, 1'b1, HS_CONST, 8'd1, 1'b0);
      6'd32: w = mk(NS_LO,   OS_CONST, 8'h01, 1'b0, HS_CONST, 8'd8, 1'b1);
      default: w = mk(NS_KEEP, OS_CONST, 8'h00, 1'b0, HS_CONST, 8'd0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

[design/clcd_cmd_if.sv]
// Command channel of the character LCD nibble interface.
interface clcd_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [clcd_pkg::FuncW-1:0]      func;
  logic [clcd_pkg::ByteW-1:0]      byte_value;
  logic                            row;
  logic [clcd_pkg::ColumnW-1:0]    column;

  modport source (output valid, func, byte_value, row, column, input ready);
  modport sink   (input valid, func, byte_value, row, column, output ready);
endinterface

[design/clcd_step_if.sv]
// Pin step channel of the character LCD nibble interface.
interface clcd_step_if;
  logic                            valid;
  logic                            ready;
  logic                            reg_select;
  logic [clcd_pkg::NibbleW-1:0]    data_nibble;
  logic                            enable;
  logic [clcd_pkg::HoldW-1:0]      hold_ticks;
  logic                            last;

  modport source (output valid, reg_select, data_nibble, enable, hold_ticks, last,
                  input ready);
  modport sink   (input valid, reg_select, data_nibble, enable, hold_ticks, last,
                  output ready);
endinterface

[design/char_lcd_nibble_interface.sv]
// Top level of the character LCD 4-bit nibble interface.
// Usage: each word on cmd_i asks for a data byte, a command byte, a cursor move,
// a clear or the power-up init. The block answers with a run of pin step words on
// step_o: register-select level, D7..D4 levels, enable level and the number of
// ticks to hold that pin state, with last set on the final step of the command.
// A byte, cursor move or clear gives four steps; init gives twenty-five. Unused
// function codes give no steps.
// A step counter walks a control store, one control word per step, so one step
// word is produced per clock while the output register is free. The first step
// appears once the command is held in the step counter and then in the output
// register; the next command is taken in the cycle the last step is issued.
// The configuration port sets the second-row base and the power-up wait.
// Reset clears the held register-select and nibble state, sets the second-row base
// to 0xC0 and the power-up wait to 50 ticks, and drops any command in flight.
// When the receiver stalls, the current step word is held on step_o and the
// sequencer waits; cmd_i is ready while no command is in flight or as its last step issues.
`include "char_lcd_nibble_interface_macros.svh"

module char_lcd_nibble_interface (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [clcd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [clcd_pkg::ByteW-1:0]         cfg_data_i,
  clcd_cmd_if.sink                           cmd_i,
  clcd_step_if.source                        step_o
);

  logic [clcd_pkg::ByteW-1:0]   second_row_q;
  logic [clcd_pkg::HoldW-1:0]   power_wait_q;
  logic                         busy_q, busy_d;
  logic [clcd_pkg::UpcW-1:0]    upc_q, upc_d;
  logic                         rs_q, rs_d;
  logic [clcd_pkg::NibbleW-1:0] nib_q, nib_d;
  logic [clcd_pkg::ByteW-1:0]   opnd_q, opnd_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_rs_q;
  logic [clcd_pkg::NibbleW-1:0] out_nib_q;
  logic                         out_en_q;
  logic [clcd_pkg::HoldW-1:0]   out_hold_q;
  logic                         out_last_q;

  clcd_pkg::uword_t             uw;
  logic [clcd_pkg::ByteW-1:0]   operand;
  logic [clcd_pkg::NibbleW-1:0] step_nib;
  logic [clcd_pkg::HoldW-1:0]   step_hold;
  logic                         fire;
  logic                         cmd_acc;
  logic [clcd_pkg::ByteW-1:0]   row_base;

  assign uw      = clcd_pkg::ucode(upc_q);
  assign fire    = busy_q && (!out_valid_q || step_o.ready);
  assign cmd_i.ready = !busy_q || (fire && uw.last);
  assign cmd_acc = cmd_i.valid && cmd_i.ready;
  assign operand = (uw.osel == clcd_pkg::OS_REQ) ? opnd_q : uw.cbyte;
  assign row_base = cmd_i.row ? second_row_q : clcd_pkg::FirstRowBase;

  always_comb begin
    case (uw.nsel)
      clcd_pkg::NS_HI: step_nib = operand[7:4];
      clcd_pkg::NS_LO: step_nib = operand[3:0];
      default:         step_nib = nib_q;
    endcase
    step_hold = (uw.hsel == clcd_pkg::HS_PWR) ? power_wait_q : uw.hold;
  end

  always_comb begin
    busy_d      = busy_q;
    upc_d       = upc_q;
    rs_d        = rs_q;
    nib_d       = nib_q;
    opnd_d      = opnd_q;
    out_valid_d = out_valid_q && !step_o.ready;
    if (fire) begin
      out_valid_d = 1'b1;
      nib_d       = step_nib;
      upc_d       = upc_q + 1'b1;
      if (uw.last) begin
        busy_d = 1'b0;
      end
    end
    if (cmd_acc) begin
      if (cmd_i.func inside {clcd_pkg::FuncData, clcd_pkg::FuncCmd, clcd_pkg::FuncCursor,
                             clcd_pkg::FuncClear, clcd_pkg::FuncInit}) begin
        busy_d = 1'b1;
        rs_d   = (cmd_i.func == clcd_pkg::FuncData);
      end
      case (cmd_i.func)
        clcd_pkg::FuncData, clcd_pkg::FuncCmd: begin
          upc_d  = clcd_pkg::EntryByte;
          opnd_d = cmd_i.byte_value;
        end
        clcd_pkg::FuncCursor: begin
          upc_d  = clcd_pkg::EntryByte;
          opnd_d = row_base + {{(clcd_pkg::ByteW-clcd_pkg::ColumnW){1'b0}}, cmd_i.column};
        end
        clcd_pkg::FuncClear: begin
          upc_d = clcd_pkg::EntryClear;
        end
        clcd_pkg::FuncInit: begin
          upc_d = clcd_pkg::EntryInit;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_row_q <= clcd_pkg::SecondRowReset;
      power_wait_q <= clcd_pkg::PowerWaitReset;
      busy_q       <= 1'b0;
      upc_q        <= clcd_pkg::EntryByte;
      rs_q         <= 1'b0;
      nib_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          clcd_pkg::CfgSecondRow: second_row_q <= cfg_data_i;
          clcd_pkg::CfgPowerWait: power_wait_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      rs_q        <= rs_d;
      nib_q       <= nib_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    if (fire) begin
      out_rs_q   <= rs_q;
      out_nib_q  <= step_nib;
      out_en_q   <= uw.en;
      out_hold_q <= step_hold;
      out_last_q <= uw.last;
    end
  end

  assign step_o.valid       = out_valid_q;
  assign step_o.reg_select  = out_rs_q;
  assign step_o.data_nibble = out_nib_q;
  assign step_o.enable      = out_en_q;
  assign step_o.hold_ticks  = out_hold_q;
  assign step_o.last        = out_last_q;

  `CLCD_ASSERT_SAME(a_upc_in_store, busy_q, upc_q <= clcd_pkg::LastAddr, "step counter past store")
  `CLCD_ASSERT_NEXT(a_last_ends_cmd, fire && uw.last && !cmd_i.valid, !busy_q, "busy after last")
  `CLCD_ASSERT_NEXT(a_stall_no_step, busy_q && out_valid_q && !step_o.ready,
                    out_valid_q && $stable(upc_q), "step issued into full output")

endmodule
